/* src/assert_macros.svh */
// Assertion helpers for the RTL files.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define APQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define APQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/apq_pkg.sv */
package apq_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W   = 32;
    localparam int CAP_W    = 4;
    localparam int STATUS_W = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    // Register index bit of the capacity register (byte address 0).
    localparam logic CAP_REG_IDX = 1'b0;

    // Operation codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } apq_status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RESULT
    } apq_state_t;

endpackage

/* src/array_priority_queue.sv */
// Bounded priority queue kept as an unsorted array in arrival order.
// Input channel (in_valid/in_ready): opcode selects push or pop; a push carries
// item_data and item_priority. Every accepted transfer yields exactly one result
// transfer on the output channel (out_valid/out_ready) with status, the popped
// pair (zero unless a pop succeeded), entry_count, is_empty and is_full.
// Entries live in a single-port-read, single-port-write memory. A pop walks the
// memory once to find the highest priority (oldest wins a tie), then walks again
// to move later entries down, one memory read and one write per cycle.
// A push or a rejected pop goes straight to the result state; a pop with
// entries held first scans them all, then shifts the entries behind the
// winner (slot 0 is the oldest) down before its result. A new item is taken
// only when the sequencer is idle, so no item is taken before the last result
// is staged.
// The result sits in an output register: a stall on out_ready holds it there,
// the block still accepts the next item and waits only before writing the next
// result. Reset empties the queue and sets the capacity register to 8; entry
// storage is not cleared. The capacity register sits at byte address 0 of the
// APB port and is meant to be written only while the block is idle.
module array_priority_queue #(
    parameter int DEPTH = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               opcode,
    input  logic signed [apq_pkg::DATA_W-1:0]  item_data,
    input  logic signed [apq_pkg::DATA_W-1:0]  item_priority,
    // Output channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [apq_pkg::STATUS_W-1:0]       status,
    output logic signed [apq_pkg::DATA_W-1:0]  popped_data,
    output logic signed [apq_pkg::DATA_W-1:0]  popped_priority,
    output logic [$clog2(DEPTH+1)-1:0]         entry_count,
    output logic                               is_empty,
    output logic                               is_full,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [apq_pkg::PADDR_W-1:0]        paddr,
    input  logic [apq_pkg::PDATA_W-1:0]        pwdata,
    output logic [apq_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import apq_pkg::*;

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW      = $clog2(DEPTH + 2);
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int ENTRY_W = 2 * DATA_W;

    // Control state
    apq_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CAP_W-1:0]     cap_reg;
    logic [IW-1:0]        idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;

    // Datapath registers
    logic [AW-1:0]        best_idx_reg, best_idx_next;
    logic [DATA_W-1:0]    best_data_reg, best_data_next;
    logic [DATA_W-1:0]    best_pri_reg, best_pri_next;
    apq_status_t          pend_status_reg, pend_status_next;
    logic [DATA_W-1:0]    pend_data_reg, pend_data_next;
    logic [DATA_W-1:0]    pend_pri_reg, pend_pri_next;
    apq_status_t          status_reg;
    logic [DATA_W-1:0]    pdata_reg, ppri_reg;
    logic [CNT_W-1:0]     ocount_reg;
    logic                 oempty_reg, ofull_reg;

    // Entry memory, data in the upper half and priority in the lower half
    logic [ENTRY_W-1:0]   mem [DEPTH];
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0]   mem_wdata;

    // Helper signals
    logic                 in_fire, cfg_write, out_free;
    logic [CMP_W-1:0]     cap_ext, cap_lim, count_cmp;
    logic [IW-1:0]        count_ix, idx_m1, idx_m2, best_ix, best_final_ix;
    logic [AW-1:0]        best_final;
    logic [DATA_W-1:0]    rd_data, rd_pri;
    logic                 scan_hit, scan_end, shift_end;

    // Handshake and limit decoding
    assign in_fire   = in_valid && in_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cap_ext   = CMP_W'(cap_reg);
    assign cap_lim   = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign count_cmp = CMP_W'(count_reg);
    assign count_ix  = IW'(count_reg);

    // Scan and shift bookkeeping
    assign idx_m1        = idx_reg - IW'(1);
    assign idx_m2        = idx_reg - IW'(2);
    assign rd_data       = rd_data_reg[ENTRY_W-1:DATA_W];
    assign rd_pri        = rd_data_reg[DATA_W-1:0];
    assign scan_hit      = (idx_reg == IW'(1)) ||
                           ($signed(rd_pri) > $signed(best_pri_reg));
    assign scan_end      = (idx_reg == count_ix);
    assign shift_end     = (idx_reg >= count_ix);
    assign best_final    = scan_hit ? idx_m1[AW-1:0] : best_idx_reg;
    assign best_final_ix = IW'(best_final);
    assign best_ix       = IW'(best_idx_reg);

    // The block takes a new item whenever the sequencer is idle.
    assign in_ready = (state_reg == ST_IDLE);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (opcode == OP_POP && count_reg != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (shift_end)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control for each state.
    always_comb
    begin
        count_next       = count_reg;
        idx_next         = idx_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        best_idx_next    = best_idx_reg;
        best_data_next   = best_data_reg;
        best_pri_next    = best_pri_reg;
        pend_status_next = pend_status_reg;
        pend_data_next   = pend_data_reg;
        pend_pri_next    = pend_pri_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = {item_data, item_priority};
        mem_raddr        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pend_status_next = STAT_OK;
                    pend_data_next   = '0;
                    pend_pri_next    = '0;
                    idx_next         = '0;
                    if (opcode == OP_PUSH)
                    begin
                        if (count_cmp >= cap_lim)
                        begin
                            pend_status_next = STAT_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        pend_status_next = STAT_EMPTY;
                    end
                end
            end
            ST_SCAN:
            begin
                // Read one entry a cycle; compare the entry read the cycle before.
                if (idx_reg < count_ix)
                begin
                    mem_raddr = idx_reg[AW-1:0];
                end
                if (idx_reg != '0 && scan_hit)
                begin
                    best_idx_next  = idx_m1[AW-1:0];
                    best_data_next = rd_data;
                    best_pri_next  = rd_pri;
                end
                if (scan_end)
                begin
                    idx_next = best_final_ix + IW'(1);
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_SHIFT:
            begin
                // Each entry behind the winner moves down one slot.
                if (idx_reg < count_ix)
                begin
                    mem_raddr = idx_reg[AW-1:0];
                end
                if (idx_reg >= best_ix + IW'(2))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_m2[AW-1:0];
                    mem_wdata = rd_data_reg;
                end
                idx_next = idx_reg + IW'(1);
                if (shift_end)
                begin
                    count_next     = count_reg - CNT_W'(1);
                    pend_data_next = best_data_reg;
                    pend_pri_next  = best_pri_reg;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && paddr[2] == CAP_REG_IDX)
            begin
                cap_reg <= pwdata[CAP_W-1:0];
            end
        end
    end

    // Payload registers; the result register loads when the result transfer is staged.
    always_ff @(posedge clk)
    begin
        best_idx_reg    <= best_idx_next;
        best_data_reg   <= best_data_next;
        best_pri_reg    <= best_pri_next;
        pend_status_reg <= pend_status_next;
        pend_data_reg   <= pend_data_next;
        pend_pri_reg    <= pend_pri_next;
        if (state_reg == ST_RESULT && out_free)
        begin
            status_reg <= pend_status_reg;
            pdata_reg  <= pend_data_reg;
            ppri_reg   <= pend_pri_reg;
            ocount_reg <= count_reg;
            oempty_reg <= (count_reg == '0);
            ofull_reg  <= (count_cmp >= cap_lim);
        end
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Output and configuration read drive.
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign popped_data     = pdata_reg;
    assign popped_priority = ppri_reg;
    assign entry_count     = ocount_reg;
    assign is_empty        = oempty_reg;
    assign is_full         = ofull_reg;
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == CAP_REG_IDX) ?
                             {(PDATA_W - CAP_W)'(0), cap_reg} : '0;

    // Checks on the queue bookkeeping.
    `include "assert_macros.svh"

    `APQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "entry count beyond depth")
    `APQ_ASSERT_NEXT(a_push_grows, in_fire && opcode == OP_PUSH && count_cmp < cap_lim, count_reg == $past(count_reg) + CNT_W'(1), "accepted push did not add an entry")
    `APQ_ASSERT_NOW(a_shift_winner, state_reg == ST_SHIFT, best_ix < count_ix, "winning index outside held entries")
    `APQ_ASSERT_NOW(a_reject_zero, out_valid_reg && status_reg != STAT_OK, pdata_reg == '0 && ppri_reg == '0, "rejected operation returned a nonzero pair")
    `APQ_ASSERT_NOW(a_empty_pop, out_valid_reg && status_reg == STAT_EMPTY, ocount_reg == '0 && oempty_reg, "empty pop reported entries held")

endmodule
